>>> design/mtpc_pkg.sv
// Shared types and constants for the memory test pattern checker.
// Used by mtpc_step and memory_test_pattern_checker_unit; depends on nothing.
`default_nettype none

package mtpc_pkg;

  // Field widths fixed by the interface
  localparam int unsigned OP_W     = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STRIDE_W = 19;
  // Width of offset + stride before the wrap test
  localparam int unsigned STEP_W   = STRIDE_W + 1;

  // Defaults for the top level parameters
  localparam int unsigned REGION_WORDS_DEF = 1024 * 1024 / 4;
  localparam int unsigned REPORT_LIMIT_DEF = 8;

  // Register map
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_REGION_BASE = 3'd0,
    REG_PATTERN_MOD = 3'd1,
    REG_COMPARE_VAL = 3'd2,
    REG_REPLACE_VAL = 3'd3,
    REG_SPARSE_STRIDE = 3'd4
  } reg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_START    = 3'd0,
    OP_FILL     = 3'd1,
    OP_CHK_CONST = 3'd2,
    OP_CHK_PATT = 3'd3,
    OP_SPARSE   = 3'd4,
    OP_CLEAR    = 3'd5
  } op_e;

  // Configuration as seen by the step logic
  typedef struct packed {
    logic [DATA_W-1:0]   region_base;
    logic [DATA_W-1:0]   pattern_modifier;
    logic [DATA_W-1:0]   compare_value;
    logic [DATA_W-1:0]   replace_value;
    logic [STRIDE_W-1:0] sparse_stride;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic [DATA_W-1:0] word_address;
    logic [DATA_W-1:0] write_data;
    logic              write_enable;
    logic              mismatch;
    logic              report_error;
    logic [DATA_W-1:0] error_total;
    logic              region_done;
  } result_t;

endpackage

`default_nettype wire

>>> design/mtpc_step.sv
// Single-step datapath of the memory test pattern checker: decodes one
// operation and forms the result word and next walk state. Uses mtpc_pkg.
`default_nettype none

module mtpc_step #(
  parameter int unsigned REGION_WORDS = mtpc_pkg::REGION_WORDS_DEF,
  parameter int unsigned REPORT_LIMIT = mtpc_pkg::REPORT_LIMIT_DEF,
  localparam int unsigned OFF_W = $clog2(REGION_WORDS)
) (
  input  wire logic [mtpc_pkg::OP_W-1:0]   operation_i,
  input  wire logic [mtpc_pkg::DATA_W-1:0] read_data_i,
  input  wire mtpc_pkg::cfg_t              cfg_i,
  input  wire logic [OFF_W-1:0]            offset_i,
  input  wire logic [mtpc_pkg::DATA_W-1:0] count_i,
  output mtpc_pkg::result_t                result_o,
  output logic [OFF_W-1:0]                 offset_o,
  output logic [mtpc_pkg::DATA_W-1:0]      count_o
);

  localparam int unsigned DW = mtpc_pkg::DATA_W;
  localparam int unsigned SW = mtpc_pkg::STRIDE_W;
  localparam int unsigned TW = mtpc_pkg::STEP_W;

  logic [DW-1:0] off_bytes;
  logic [DW-1:0] addr;
  logic [DW-1:0] line_addr;
  logic [DW-1:0] pattern;
  logic [SW-1:0] stride;
  logic [TW-1:0] step_by;
  logic [TW-1:0] next_off;
  logic          wrap;
  logic          count_full;
  logic [DW-1:0] count_inc;
  logic          const_miss;
  logic          patt_miss;

  // Word address and the line-based pattern of the current word
  assign off_bytes = {{(DW-OFF_W-2){1'b0}}, offset_i, 2'b00};
  assign addr      = cfg_i.region_base + off_bytes;
  assign line_addr = cfg_i.region_base + {off_bytes[DW-1:4], 4'b0000};
  assign pattern   = {line_addr[DW-3:0], 2'b00} ^ cfg_i.pattern_modifier
                   ^ {{(DW-2){1'b0}}, offset_i[1:0]};

  // Zero stride behaves as one
  assign stride   = (cfg_i.sparse_stride == '0) ? SW'(1) : cfg_i.sparse_stride;

  assign next_off = {{(TW-OFF_W){1'b0}}, offset_i} + step_by;
  assign wrap     = (next_off >= TW'(REGION_WORDS));

  assign count_full = (count_i == '1);
  assign count_inc  = count_i + DW'(1);
  assign const_miss = (read_data_i != cfg_i.compare_value);
  assign patt_miss  = (read_data_i != pattern);

  always_comb begin
    result_o              = '0;
    result_o.word_address = addr;
    offset_o              = offset_i;
    count_o               = count_i;
    step_by               = '0;

    case (mtpc_pkg::op_e'(operation_i))
      mtpc_pkg::OP_START: begin
        offset_o              = '0;
        result_o.word_address = cfg_i.region_base;
      end
      mtpc_pkg::OP_FILL: begin
        result_o.write_data   = pattern;
        result_o.write_enable = 1'b1;
        step_by               = TW'(1);
      end
      mtpc_pkg::OP_CHK_CONST: begin
        result_o.mismatch = const_miss;
        if (const_miss && !count_full) count_o = count_inc;
        step_by           = TW'(1);
      end
      mtpc_pkg::OP_CHK_PATT: begin
        result_o.mismatch = patt_miss;
        if (patt_miss && !count_full) begin
          count_o               = count_inc;
          result_o.report_error = (count_inc <= DW'(REPORT_LIMIT));
        end
        step_by           = TW'(1);
      end
      mtpc_pkg::OP_SPARSE: begin
        result_o.mismatch     = const_miss;
        if (const_miss && !count_full) begin
          count_o               = count_inc;
          result_o.report_error = (count_inc <= DW'(REPORT_LIMIT));
        end
        result_o.write_data   = cfg_i.replace_value;
        result_o.write_enable = 1'b1;
        step_by               = {1'b0, stride};
      end
      mtpc_pkg::OP_CLEAR: begin
        count_o = '0;
      end
      default: begin
      end
    endcase

    // Advance only for the walking operations; wrap to the region start
    if (step_by != '0) begin
      result_o.region_done = wrap;
      offset_o             = wrap ? '0 : next_off[OFF_W-1:0];
    end
    result_o.error_total = count_o;
  end

endmodule

`default_nettype wire

>>> design/memory_test_pattern_checker_unit.sv
// Top level of the memory test pattern checker: APB register file, input
// word register, walk state and result register. Uses mtpc_pkg, mtpc_step.
//
//   channel   direction  handshake                  payload
//   input     in         in_valid_i / in_ready_o    operation_i, read_data_i
//   result    out        out_valid_o / out_ready_i  word_address_o .. region_done_o
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One word per cycle while the result side drains: an accepted word sits in
// the input register and the combinational step logic (adder, compare, counter
// increment) forms its result, which the result register loads once it is
// free. A stalled result register holds the input stage, which keeps its word
// and drops ready; reset clears the valid flags, the walk offset, the error
// count and the configuration (stride to one).
`default_nettype none

module memory_test_pattern_checker_unit #(
  parameter int unsigned REGION_WORDS = mtpc_pkg::REGION_WORDS_DEF,
  parameter int unsigned REPORT_LIMIT = mtpc_pkg::REPORT_LIMIT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // APB configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mtpc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mtpc_pkg::DATA_W-1:0]   pwdata,
  output logic      [mtpc_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  // input words
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [mtpc_pkg::OP_W-1:0]     operation_i,
  input  wire logic [mtpc_pkg::DATA_W-1:0]   read_data_i,
  // result words
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [mtpc_pkg::DATA_W-1:0]   word_address_o,
  output logic      [mtpc_pkg::DATA_W-1:0]   write_data_o,
  output logic                               write_enable_o,
  output logic                               mismatch_o,
  output logic                               report_error_o,
  output logic      [mtpc_pkg::DATA_W-1:0]   error_total_o,
  output logic                               region_done_o
);

  localparam int unsigned OFF_W = $clog2(REGION_WORDS);
  localparam int unsigned DW    = mtpc_pkg::DATA_W;
  localparam int unsigned SW    = mtpc_pkg::STRIDE_W;

  // ---------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------
  mtpc_pkg::cfg_t cfg_q;
  logic           cfg_wr;
  mtpc_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = mtpc_pkg::reg_idx_e'(paddr[mtpc_pkg::PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_base      <= '0;
      cfg_q.pattern_modifier <= '0;
      cfg_q.compare_value    <= '0;
      cfg_q.replace_value    <= '0;
      cfg_q.sparse_stride    <= mtpc_pkg::STRIDE_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        mtpc_pkg::REG_REGION_BASE:   cfg_q.region_base      <= pwdata;
        mtpc_pkg::REG_PATTERN_MOD:   cfg_q.pattern_modifier <= pwdata;
        mtpc_pkg::REG_COMPARE_VAL:   cfg_q.compare_value    <= pwdata;
        mtpc_pkg::REG_REPLACE_VAL:   cfg_q.replace_value    <= pwdata;
        mtpc_pkg::REG_SPARSE_STRIDE: cfg_q.sparse_stride    <= pwdata[SW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back; addresses past the last register return zero
  always_comb begin
    case (reg_idx)
      mtpc_pkg::REG_REGION_BASE:   prdata = cfg_q.region_base;
      mtpc_pkg::REG_PATTERN_MOD:   prdata = cfg_q.pattern_modifier;
      mtpc_pkg::REG_COMPARE_VAL:   prdata = cfg_q.compare_value;
      mtpc_pkg::REG_REPLACE_VAL:   prdata = cfg_q.replace_value;
      mtpc_pkg::REG_SPARSE_STRIDE: prdata = {{(DW-SW){1'b0}}, cfg_q.sparse_stride};
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic                       in_vld_q;
  logic [mtpc_pkg::OP_W-1:0]  op_q;
  logic [DW-1:0]              rd_q;
  logic                       out_free;
  logic                       step_go;

  // Result register can take a word when empty or being drained
  assign out_free   = !out_valid_o || out_ready_i;
  assign step_go    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || step_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Payload: hold until the stage moves on
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q <= operation_i;
      rd_q <= read_data_i;
    end
  end

  // ---------------------------------------------------------------------
  // Walk state and step logic
  // ---------------------------------------------------------------------
  logic [OFF_W-1:0]   offset_q, offset_d;
  logic [DW-1:0]      count_q, count_d;
  mtpc_pkg::result_t  res_d, res_q;

  mtpc_step #(
    .REGION_WORDS(REGION_WORDS),
    .REPORT_LIMIT(REPORT_LIMIT)
  ) u_step (
    .operation_i(op_q),
    .read_data_i(rd_q),
    .cfg_i      (cfg_q),
    .offset_i   (offset_q),
    .count_i    (count_q),
    .result_o   (res_d),
    .offset_o   (offset_d),
    .count_o    (count_d)
  );

  // Advance the walk state only when the word moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      count_q  <= '0;
    end else if (step_go) begin
      offset_q <= offset_d;
      count_q  <= count_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      res_q <= res_d;
    end
  end

  assign word_address_o = res_q.word_address;
  assign write_data_o   = res_q.write_data;
  assign write_enable_o = res_q.write_enable;
  assign mismatch_o     = res_q.mismatch;
  assign report_error_o = res_q.report_error;
  assign error_total_o  = res_q.error_total;
  assign region_done_o  = res_q.region_done;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking bench for memory_test_pattern_checker_unit: random and directed walk
// steps, APB register phases and a scoreboard fed by a behavioural model of the walk.
// Depends on mtpc_pkg and the unit's RTL only.
`default_nettype none

module tb_top;

  // One pending step. With use_raw set, read_data goes out as given. Otherwise
  // rd_word is an XOR mask laid over the value the memory should hold at that
  // moment, so a zero mask gives a clean read and anything else is a fault.
  typedef struct {
    logic [mtpc_pkg::OP_W-1:0]   op;
    bit                          use_raw;
    logic [mtpc_pkg::DATA_W-1:0] rd_word;
  } walk_cmd_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [mtpc_pkg::PADDR_W-1:0]  paddr = '0;
  logic [mtpc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [mtpc_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [mtpc_pkg::OP_W-1:0]     operation_i = '0;
  logic [mtpc_pkg::DATA_W-1:0]   read_data_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [mtpc_pkg::DATA_W-1:0]   word_address_o;
  logic [mtpc_pkg::DATA_W-1:0]   write_data_o;
  logic                          write_enable_o;
  logic                          mismatch_o;
  logic                          report_error_o;
  logic [mtpc_pkg::DATA_W-1:0]   error_total_o;
  logic                          region_done_o;

  memory_test_pattern_checker_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .read_data_i    (read_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .word_address_o (word_address_o),
    .write_data_o   (write_data_o),
    .write_enable_o (write_enable_o),
    .mismatch_o     (mismatch_o),
    .report_error_o (report_error_o),
    .error_total_o  (error_total_o),
    .region_done_o  (region_done_o)
  );

  // Model state: a shadow of the register file plus the walk position and
  // the error counter, advanced once per accepted word.
  mtpc_pkg::cfg_t                walk_cfg;
  logic [mtpc_pkg::STRIDE_W-1:0] walk_off = '0;
  logic [mtpc_pkg::DATA_W-1:0]   err_total = '0;

  walk_cmd_t          steps_to_send[$];
  mtpc_pkg::result_t  walk_results_due[$];
  int                 steps_issued = 0;
  int                 steps_taken = 0;
  int                 fault_count = 0;

  // Idle shaping: upper bounds of the per-word waits, plus the long hold-off
  int send_gap_max = 0;
  int recv_gap_max = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int hold_left = 0;
  logic hold_start = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // Walk model
  // ------------------------------------------------------------------------

  // Pattern of the word at offset off: address of its 16-byte line shifted
  // left two, XOR modifier, XOR the word's place in the line.
  function automatic logic [mtpc_pkg::DATA_W-1:0] pattern_at(
      logic [mtpc_pkg::STRIDE_W-1:0] off);
    logic [mtpc_pkg::DATA_W-1:0] line_addr;
    line_addr = walk_cfg.region_base
              + mtpc_pkg::DATA_W'({off[mtpc_pkg::STRIDE_W-1:2], 4'b0000});
    return (line_addr << 2) ^ walk_cfg.pattern_modifier ^ mtpc_pkg::DATA_W'(off[1:0]);
  endfunction

  // Count one error; the counter sticks at all ones and stops reporting there.
  function automatic bit bump_errors();
    if (err_total == '1) return 1'b0;
    err_total = err_total + 1'b1;
    return err_total <= mtpc_pkg::DATA_W'(mtpc_pkg::REPORT_LIMIT_DEF);
  endfunction

  // Move the walk on; reaching or passing the region end wraps to offset zero.
  function automatic bit walk_advance(logic [mtpc_pkg::DATA_W-1:0] hop);
    logic [mtpc_pkg::DATA_W-1:0] next_off;
    next_off = mtpc_pkg::DATA_W'(walk_off) + hop;
    if (next_off >= mtpc_pkg::DATA_W'(mtpc_pkg::REGION_WORDS_DEF)) begin
      walk_off = '0;
      return 1'b1;
    end
    walk_off = next_off[mtpc_pkg::STRIDE_W-1:0];
    return 1'b0;
  endfunction

  // Apply one word to the model and return the result it must produce.
  function automatic mtpc_pkg::result_t walk_step(logic [mtpc_pkg::OP_W-1:0] op,
                                                  logic [mtpc_pkg::DATA_W-1:0] rd);
    mtpc_pkg::result_t r;
    r = '0;
    r.word_address = walk_cfg.region_base + mtpc_pkg::DATA_W'({walk_off, 2'b00});
    case (op)
      mtpc_pkg::OP_START: begin
        walk_off = '0;
        r.word_address = walk_cfg.region_base;
      end
      mtpc_pkg::OP_FILL: begin
        r.write_data = pattern_at(walk_off);
        r.write_enable = 1'b1;
        r.region_done = walk_advance(1);
      end
      mtpc_pkg::OP_CHK_CONST: begin
        // constant checks count but never report
        r.mismatch = rd != walk_cfg.compare_value;
        if (r.mismatch) void'(bump_errors());
        r.region_done = walk_advance(1);
      end
      mtpc_pkg::OP_CHK_PATT: begin
        r.mismatch = rd != pattern_at(walk_off);
        if (r.mismatch) r.report_error = bump_errors();
        r.region_done = walk_advance(1);
      end
      mtpc_pkg::OP_SPARSE: begin
        r.mismatch = rd != walk_cfg.compare_value;
        if (r.mismatch) r.report_error = bump_errors();
        r.write_data = walk_cfg.replace_value;
        r.write_enable = 1'b1;
        // a zero stride still moves one word
        r.region_done = walk_advance((walk_cfg.sparse_stride == '0) ?
                                     mtpc_pkg::DATA_W'(1) :
                                     mtpc_pkg::DATA_W'(walk_cfg.sparse_stride));
      end
      mtpc_pkg::OP_CLEAR: begin
        err_total = '0;
      end
      default: begin
        // unused codes leave the walk alone
      end
    endcase
    r.error_total = err_total;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Scoreboard helpers
  // ------------------------------------------------------------------------

  task automatic note_fault(string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    fault_count++;
  endtask

  task automatic check_field(string what, logic [mtpc_pkg::DATA_W-1:0] got,
                             logic [mtpc_pkg::DATA_W-1:0] want);
    if (got !== want)
      note_fault($sformatf("%s got %h want %h", what, got, want));
  endtask

  // ------------------------------------------------------------------------
  // Input driver: launch the next pending step whenever the slot frees up,
  // predicting each word at the edge it is taken.
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    walk_cmd_t                   c;
    logic [mtpc_pkg::DATA_W-1:0] clean_rd;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait  <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        // push the expectation before counting the word as taken
        walk_results_due.push_back(walk_step(operation_i, read_data_i));
        steps_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_wait != 0) begin
          in_valid_i <= 1'b0;
          send_wait  <= send_wait - 1;
        end else if (steps_to_send.size() != 0) begin
          c = steps_to_send.pop_front();
          // model state already includes every earlier word, so the clean
          // value is the one the memory holds at the current offset
          case (c.op)
            mtpc_pkg::OP_CHK_PATT:   clean_rd = pattern_at(walk_off);
            mtpc_pkg::OP_CHK_CONST,
            mtpc_pkg::OP_SPARSE:     clean_rd = walk_cfg.compare_value;
            default:                 clean_rd = '0;
          endcase
          in_valid_i  <= 1'b1;
          operation_i <= c.op;
          read_data_i <= c.use_raw ? c.rd_word : (clean_rd ^ c.rd_word);
          send_wait   <= $urandom_range(0, send_gap_max);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the result side, counted here so that the driver keeps
  // offering words and the unit backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= 150;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ------------------------------------------------------------------------
  // Result monitor: check each accepted word against the oldest expectation,
  // then draw the stall before the next one.
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    mtpc_pkg::result_t want;
    int                n;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (walk_results_due.size() == 0) begin
          note_fault($sformatf("result with nothing pending, address %h", word_address_o));
        end else begin
          want = walk_results_due.pop_front();
          check_field("word_address", word_address_o, want.word_address);
          check_field("write_data", write_data_o, want.write_data);
          check_field("write_enable", mtpc_pkg::DATA_W'(write_enable_o),
                      mtpc_pkg::DATA_W'(want.write_enable));
          check_field("mismatch", mtpc_pkg::DATA_W'(mismatch_o),
                      mtpc_pkg::DATA_W'(want.mismatch));
          check_field("report_error", mtpc_pkg::DATA_W'(report_error_o),
                      mtpc_pkg::DATA_W'(want.report_error));
          check_field("error_total", error_total_o, want.error_total);
          check_field("region_done", mtpc_pkg::DATA_W'(region_done_o),
                      mtpc_pkg::DATA_W'(want.region_done));
        end
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (out_valid_o && out_ready_i) begin
        n = $urandom_range(0, recv_gap_max);
        recv_wait   <= n;
        out_ready_i <= (n == 0);
      end else if (recv_wait != 0) begin
        recv_wait   <= recv_wait - 1;
        out_ready_i <= (recv_wait == 1);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  task automatic queue_step(logic [mtpc_pkg::OP_W-1:0] op, bit use_raw,
                            logic [mtpc_pkg::DATA_W-1:0] rd_word);
    walk_cmd_t c;
    c.op      = op;
    c.use_raw = use_raw;
    c.rd_word = rd_word;
    steps_to_send.push_back(c);
    steps_issued++;
  endtask

  // Wait until every queued word has been taken and answered, then allow for
  // the two-register pipe with some margin.
  task automatic settle();
    while (steps_taken != steps_issued || walk_results_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(mtpc_pkg::reg_idx_e idx, logic [mtpc_pkg::DATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      mtpc_pkg::REG_REGION_BASE:   walk_cfg.region_base = val;
      mtpc_pkg::REG_PATTERN_MOD:   walk_cfg.pattern_modifier = val;
      mtpc_pkg::REG_COMPARE_VAL:   walk_cfg.compare_value = val;
      mtpc_pkg::REG_REPLACE_VAL:   walk_cfg.replace_value = val;
      mtpc_pkg::REG_SPARSE_STRIDE: walk_cfg.sparse_stride = val[mtpc_pkg::STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  // Read back one register, sampling prdata mid-way through the access phase.
  task automatic check_register(mtpc_pkg::reg_idx_e idx);
    logic [mtpc_pkg::DATA_W-1:0] got;
    logic [mtpc_pkg::DATA_W-1:0] want;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    got = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      mtpc_pkg::REG_REGION_BASE:   want = walk_cfg.region_base;
      mtpc_pkg::REG_PATTERN_MOD:   want = walk_cfg.pattern_modifier;
      mtpc_pkg::REG_COMPARE_VAL:   want = walk_cfg.compare_value;
      mtpc_pkg::REG_REPLACE_VAL:   want = walk_cfg.replace_value;
      default:                     want = mtpc_pkg::DATA_W'(walk_cfg.sparse_stride);
    endcase
    check_field($sformatf("register %s", idx.name()), got, want);
  endtask

  // Drain, then write every register and read them all back.
  task automatic set_walk_config(logic [mtpc_pkg::DATA_W-1:0] base,
                                 logic [mtpc_pkg::DATA_W-1:0] modifier,
                                 logic [mtpc_pkg::DATA_W-1:0] cmp,
                                 logic [mtpc_pkg::DATA_W-1:0] repl,
                                 logic [mtpc_pkg::DATA_W-1:0] stride);
    settle();
    apb_write(mtpc_pkg::REG_REGION_BASE, base);
    apb_write(mtpc_pkg::REG_PATTERN_MOD, modifier);
    apb_write(mtpc_pkg::REG_COMPARE_VAL, cmp);
    apb_write(mtpc_pkg::REG_REPLACE_VAL, repl);
    apb_write(mtpc_pkg::REG_SPARSE_STRIDE, stride);
    for (int i = 0; i <= int'(mtpc_pkg::REG_SPARSE_STRIDE); i++)
      check_register(mtpc_pkg::reg_idx_e'(i));
  endtask

  // Register value biased towards the extremes
  function automatic logic [mtpc_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'hFFFF_FFF0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [mtpc_pkg::DATA_W-1:0] pick_stride();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return $urandom_range(2, 7);
      3:       return mtpc_pkg::REGION_WORDS_DEF;
      4:       return mtpc_pkg::REGION_WORDS_DEF - 1;
      5:       return {mtpc_pkg::STRIDE_W{1'b1}};
      6:       return $urandom_range(1, mtpc_pkg::REGION_WORDS_DEF);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 11;
    endcase
  endfunction

  // Mostly well-formed checks with clean reads; a minority of reads carry a
  // single flipped bit or random garbage to drive the error counter.
  task automatic queue_random_steps(int count);
    int                          pick;
    logic [mtpc_pkg::OP_W-1:0]   op;
    logic [mtpc_pkg::DATA_W-1:0] mask;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)       op = mtpc_pkg::OP_START;
      else if (pick < 24) op = mtpc_pkg::OP_FILL;
      else if (pick < 39) op = mtpc_pkg::OP_CHK_CONST;
      else if (pick < 69) op = mtpc_pkg::OP_CHK_PATT;
      else if (pick < 90) op = mtpc_pkg::OP_SPARSE;
      else if (pick < 96) op = mtpc_pkg::OP_CLEAR;
      else                op = mtpc_pkg::OP_W'($urandom_range(6, 7));
      if (op == mtpc_pkg::OP_CHK_CONST || op == mtpc_pkg::OP_CHK_PATT ||
          op == mtpc_pkg::OP_SPARSE) begin
        mask = '0;
        if ($urandom_range(0, 99) < 15) begin
          mask = $urandom_range(0, 1) ?
                 (mtpc_pkg::DATA_W'(1) << $urandom_range(0, mtpc_pkg::DATA_W - 1)) :
                 mtpc_pkg::DATA_W'($urandom);
          if (mask == '0) mask = '1;
        end
        queue_step(op, 1'b0, mask);
      end else begin
        queue_step(op, 1'b1, $urandom);
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------
  initial begin
    walk_cfg = '0;
    walk_cfg.sparse_stride = mtpc_pkg::STRIDE_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the reset configuration: unused codes, start, fill,
    // both constant-check outcomes, then a run of pattern faults that carries
    // the count past the report limit.
    queue_step(mtpc_pkg::OP_W'(6), 1'b1, '1);
    queue_step(mtpc_pkg::OP_W'(7), 1'b1, '0);
    queue_step(mtpc_pkg::OP_START, 1'b1, '0);
    queue_step(mtpc_pkg::OP_FILL, 1'b1, '1);
    queue_step(mtpc_pkg::OP_FILL, 1'b1, '0);
    queue_step(mtpc_pkg::OP_CHK_CONST, 1'b0, '0);
    queue_step(mtpc_pkg::OP_CHK_CONST, 1'b1, '1);
    queue_step(mtpc_pkg::OP_CHK_PATT, 1'b0, '0);
    for (int k = 0; k < 8; k++)
      queue_step(mtpc_pkg::OP_CHK_PATT, 1'b0, mtpc_pkg::DATA_W'(1) << (k * 4 + 3));
    queue_step(mtpc_pkg::OP_SPARSE, 1'b0, '0);
    queue_step(mtpc_pkg::OP_CLEAR, 1'b1, '0);
    // clearing the count re-arms reporting
    queue_step(mtpc_pkg::OP_SPARSE, 1'b0, '1);

    // Stride one short of the region: a sparse step lands on the last word and
    // the next fill runs off the end.
    set_walk_config(32'hFFFF_FFF0, '1, '1, 32'hA5A5_5A5A, mtpc_pkg::REGION_WORDS_DEF - 1);
    queue_step(mtpc_pkg::OP_START, 1'b1, $urandom);
    queue_step(mtpc_pkg::OP_SPARSE, 1'b0, '0);
    queue_step(mtpc_pkg::OP_FILL, 1'b1, '0);
    queue_step(mtpc_pkg::OP_SPARSE, 1'b0, 32'h0000_0001);
    queue_step(mtpc_pkg::OP_CHK_PATT, 1'b0, '0);

    // Zero stride still moves one word
    set_walk_config('1, 32'h5555_5555, '0, '1, 0);
    queue_step(mtpc_pkg::OP_SPARSE, 1'b0, '0);
    queue_step(mtpc_pkg::OP_SPARSE, 1'b0, 32'h8000_0000);

    // Widest stride the register holds
    set_walk_config(32'h0000_0010, 32'hAAAA_AAAA, 32'h1234_5678, '0,
                    {mtpc_pkg::STRIDE_W{1'b1}});
    queue_step(mtpc_pkg::OP_SPARSE, 1'b0, '0);
    queue_step(mtpc_pkg::OP_CHK_PATT, 1'b1, '0);

    // Random phases: the first two pin the register extremes, later ones draw
    // fresh settings and idle shapes. One phase blocks the result side for a
    // long stretch while the sender keeps going.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0)
        set_walk_config('0, '0, '0, '0, 1);
      else if (ph == 1)
        set_walk_config('1, '1, '1, '1, mtpc_pkg::REGION_WORDS_DEF);
      else
        set_walk_config(pick_word(), pick_word(), pick_word(), pick_word(), pick_stride());
      if (ph == 4) begin
        send_gap_max = 0;
        recv_gap_max = 0;
        queue_random_steps(225);
        @(posedge clk_i);
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end else begin
        send_gap_max = (ph == 2) ? 0 : pick_gap_max();
        recv_gap_max = (ph == 2) ? 0 : pick_gap_max();
        queue_random_steps(225);
      end
    end

    // Drain, give the pipe time to show any stray word, then conclude.
    settle();
    repeat (20) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under a tenth of this.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
